### rtl/uniform_grid_sprite_broadphase_core_defines.svh
// Assertion macros shared by the broadphase RTL.
`ifndef UNIFORM_GRID_SPRITE_BROADPHASE_CORE_DEFINES_SVH
`define UNIFORM_GRID_SPRITE_BROADPHASE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define UGSB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("UGSB assertion failed");
`define UGSB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("UGSB assertion failed");
`else
`define UGSB_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define UGSB_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/ugsb_pkg.sv
// Types and constants of the uniform grid sprite broadphase.
package ugsb_pkg;
   localparam int MODE_W = 2;
   localparam int COORD_W = 12;
   localparam int SIZE_W = 11;
   localparam int ID_W = 6;
   localparam int STATUS_W = 3;
   localparam int IDS = 64;
   localparam int EDGE_W = 14;
   localparam int QUO_W = 13;
   localparam int DVSR_W = 10;
   localparam int DIV_LANES = 4;

   localparam int LANE_X_LO = 0;
   localparam int LANE_X_HI = 1;
   localparam int LANE_Y_LO = 2;
   localparam int LANE_Y_HI = 3;

   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_FOUND = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_INSERTED = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED = 3'd4;

   typedef enum logic [3:0] {
      S_SWEEP,
      S_IDLE,
      S_RANGE,
      S_SETUP,
      S_CELL,
      S_FILL,
      S_ENT_RD,
      S_ENT_CHK,
      S_ADVANCE,
      S_FINISH
   } state_type;

   typedef logic [QUO_W-1:0] quo_type;
   typedef quo_type [DIV_LANES-1:0] quo_vec_type;

   typedef struct packed {
      logic fill_rd;
      logic fill_wr;
      logic ent_rd;
      logic ent_wr;
   } mem_ctl_type;
endpackage

### rtl/ugsb_div.sv
// Four-lane reciprocal multiplier that turns box edges into cell coordinates.
module ugsb_div #(
   parameter int CELL_WIDTH = 32,
   parameter int CELL_HEIGHT = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  ugsb_pkg::quo_vec_type dividend,
   output ugsb_pkg::quo_vec_type quotient,
   output logic                  busy,
   output logic                  done
);
   import ugsb_pkg::*;

   // The reciprocal is rounded up with enough fraction bits that the quotient is exact
   // for every dividend below 2**QUO_W.
   localparam int DIV_X = 2 * CELL_WIDTH;
   localparam int DIV_Y = 2 * CELL_HEIGHT;
   localparam int SHIFT_X = QUO_W + $clog2(DIV_X);
   localparam int SHIFT_Y = QUO_W + $clog2(DIV_Y);
   localparam int RECIP_W = QUO_W + 2;
   localparam int PROD_W = QUO_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_X = RECIP_W'(((1 << SHIFT_X) + DIV_X - 1) / DIV_X);
   localparam logic [RECIP_W-1:0] RECIP_Y = RECIP_W'(((1 << SHIFT_Y) + DIV_Y - 1) / DIV_Y);

   logic done_ff, done_in;
   quo_vec_type quo_ff, quo_in;

   always_comb begin
      logic [PROD_W-1:0] prod;
      quo_vec_type       calc;
      calc = '0;
      for (int l = 0; l < DIV_LANES; l++) begin
         if (l < LANE_Y_LO) begin
            prod = {{RECIP_W{1'b0}}, dividend[l]} * {{QUO_W{1'b0}}, RECIP_X};
            calc[l] = QUO_W'(prod >> SHIFT_X);
         end else begin
            prod = {{RECIP_W{1'b0}}, dividend[l]} * {{QUO_W{1'b0}}, RECIP_Y};
            calc[l] = QUO_W'(prod >> SHIFT_Y);
         end
      end
      quo_in = start ? calc : quo_ff;
      done_in = start;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign busy = done_ff;
   assign done = done_ff;
endmodule

### rtl/ugsb_store.sv
// Cell fill counts and cell entry memories, both with registered reads.
module ugsb_store #(
   parameter int CELLS = 128,
   parameter int ENTRIES = 2048,
   parameter int CELL_W = 7,
   parameter int ENT_W = 11,
   parameter int FILL_W = 5
) (
   input  logic                       clock,
   input  ugsb_pkg::mem_ctl_type      ctl,
   input  logic [CELL_W-1:0]          fill_rd_addr,
   input  logic [CELL_W-1:0]          fill_wr_addr,
   input  logic [FILL_W-1:0]          fill_wr_data,
   output logic [FILL_W-1:0]          fill_rd_data,
   input  logic [ENT_W-1:0]           ent_rd_addr,
   input  logic [ENT_W-1:0]           ent_wr_addr,
   input  logic [ugsb_pkg::ID_W-1:0]  ent_wr_data,
   output logic [ugsb_pkg::ID_W-1:0]  ent_rd_data
);
   import ugsb_pkg::*;

   logic [FILL_W-1:0] fill_mem [CELLS];
   logic [ID_W-1:0]   ent_mem [ENTRIES];
   logic [FILL_W-1:0] fill_q_ff;
   logic [ID_W-1:0]   ent_q_ff;

   always_ff @(posedge clock) begin
      if (ctl.fill_wr) begin
         fill_mem[fill_wr_addr] <= fill_wr_data;
      end
      if (ctl.fill_rd) begin
         fill_q_ff <= fill_mem[fill_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ent_wr) begin
         ent_mem[ent_wr_addr] <= ent_wr_data;
      end
      if (ctl.ent_rd) begin
         ent_q_ff <= ent_mem[ent_rd_addr];
      end
   end

   assign fill_rd_data = fill_q_ff;
   assign ent_rd_data = ent_q_ff;
endmodule

### rtl/uniform_grid_sprite_broadphase_core.sv
// Uniform grid broadphase: an insert or query beat walks the covered cells in memory.
// Each request beat is one operation, taken one at a time. After reset the block sweeps
// the fill-count memory once, one cell per cycle over all CELLS_PER_ROW * CELLS_PER_COLUMN
// cells (128 by default), before it takes the first beat; a clear runs the same sweep
// and then returns one beat. An insert or query first turns the box edges into a cell
// range with a reciprocal multiply (S_RANGE) and sets up the walk (S_SETUP), then passes
// S_CELL, S_FILL and S_ADVANCE per covered cell for the fill-count read and the advance,
// and a query adds S_ENT_RD and S_ENT_CHK per stored entry for the entry read and the
// seen-set check. Results leave through one output register, and a query stalls its walk
// while a new result finds that register held by a stalled response.
`include "uniform_grid_sprite_broadphase_core_defines.svh"
module uniform_grid_sprite_broadphase_core #(
   parameter int CELL_WIDTH = 32,
   parameter int CELL_HEIGHT = 32,
   parameter int CELLS_PER_ROW = 16,
   parameter int CELLS_PER_COLUMN = 8,
   parameter int CELL_CAPACITY = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ugsb_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [ugsb_pkg::COORD_W-1:0]  req_center_x,
   input  logic signed [ugsb_pkg::COORD_W-1:0]  req_center_y,
   input  logic [ugsb_pkg::SIZE_W-1:0]          req_box_width,
   input  logic [ugsb_pkg::SIZE_W-1:0]          req_box_height,
   input  logic [ugsb_pkg::ID_W-1:0]            req_sprite_id,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ugsb_pkg::ID_W-1:0]            rsp_found_id,
   output logic [ugsb_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                 rsp_last
);
   import ugsb_pkg::*;

   localparam int CELLS = CELLS_PER_ROW * CELLS_PER_COLUMN;
   localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int ENTRIES = CELLS * CELL_CAPACITY;
   localparam int ENT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int FILL_W = $clog2(CELL_CAPACITY + 1);
   localparam int X_W = (CELLS_PER_ROW > 1) ? $clog2(CELLS_PER_ROW) : 1;
   localparam int Y_W = (CELLS_PER_COLUMN > 1) ? $clog2(CELLS_PER_COLUMN) : 1;
   localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(CELLS - 1);
   localparam logic [FILL_W-1:0] CAP_F = FILL_W'(CELL_CAPACITY);
   localparam quo_type QX_MAX = QUO_W'(CELLS_PER_ROW - 1);
   localparam quo_type QY_MAX = QUO_W'(CELLS_PER_COLUMN - 1);

   state_type state_ff, state_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic report_ff, report_in;
   logic lo_neg_x_ff, lo_neg_x_in, hi_neg_x_ff, hi_neg_x_in;
   logic lo_neg_y_ff, lo_neg_y_in, hi_neg_y_ff, hi_neg_y_in;
   logic [CELL_W-1:0] sweep_ff, sweep_in;
   logic [X_W-1:0] x0_ff, x0_in, x1_ff, x1_in, x_ff, x_in;
   logic [Y_W-1:0] y0_ff, y0_in, y1_ff, y1_in, y_ff, y_in;
   logic [CELL_W-1:0] row_ff, row_in, cell_ff, cell_in;
   logic [ENT_W-1:0] ent_base_ff, ent_base_in;
   logic [FILL_W-1:0] fill_cnt_ff, fill_cnt_in, idx_ff, idx_in;
   logic [IDS-1:0] seen_ff, seen_in;
   logic pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0] pend_id_ff, pend_id_in;
   logic dropped_ff, dropped_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic rsp_last_ff, rsp_last_in;

   logic accept, walk_start, out_free, out_load;
   logic [EDGE_W-1:0] ex_lo, ex_hi, ey_lo, ey_hi;
   quo_vec_type div_dividend, div_quotient;
   logic div_busy, div_done;
   quo_type xa, xb, ya, yb;
   logic x_empty, y_empty;
   mem_ctl_type mem_ctl;
   logic [CELL_W-1:0] fill_rd_addr, fill_wr_addr;
   logic [FILL_W-1:0] fill_wr_data, fill_rd_data;
   logic [ENT_W-1:0] ent_rd_addr, ent_wr_addr;
   logic [ID_W-1:0] ent_wr_data, ent_rd_data;
   logic ent_new, ent_hold, ent_last;
   logic [FILL_W-1:0] idx_nxt;

   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign walk_start = accept && (req_mode == MODE_INSERT || req_mode == MODE_QUERY);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign ex_lo = {req_center_x[COORD_W-1], req_center_x, 1'b0}
                  - {{(EDGE_W - SIZE_W){1'b0}}, req_box_width};
   assign ex_hi = {req_center_x[COORD_W-1], req_center_x, 1'b0}
                  + {{(EDGE_W - SIZE_W){1'b0}}, req_box_width};
   assign ey_lo = {req_center_y[COORD_W-1], req_center_y, 1'b0}
                  - {{(EDGE_W - SIZE_W){1'b0}}, req_box_height};
   assign ey_hi = {req_center_y[COORD_W-1], req_center_y, 1'b0}
                  + {{(EDGE_W - SIZE_W){1'b0}}, req_box_height};

   assign div_dividend[LANE_X_LO] = ex_lo[QUO_W-1:0];
   assign div_dividend[LANE_X_HI] = ex_hi[QUO_W-1:0];
   assign div_dividend[LANE_Y_LO] = ey_lo[QUO_W-1:0];
   assign div_dividend[LANE_Y_HI] = ey_hi[QUO_W-1:0];

   ugsb_div #(
      .CELL_WIDTH (CELL_WIDTH),
      .CELL_HEIGHT(CELL_HEIGHT)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (walk_start),
      .dividend(div_dividend),
      .quotient(div_quotient),
      .busy    (div_busy),
      .done    (div_done)
   );

   assign xa = lo_neg_x_ff ? '0 : div_quotient[LANE_X_LO];
   assign xb = (div_quotient[LANE_X_HI] > QX_MAX) ? QX_MAX : div_quotient[LANE_X_HI];
   assign ya = lo_neg_y_ff ? '0 : div_quotient[LANE_Y_LO];
   assign yb = (div_quotient[LANE_Y_HI] > QY_MAX) ? QY_MAX : div_quotient[LANE_Y_HI];
   assign x_empty = hi_neg_x_ff || (xa > xb);
   assign y_empty = hi_neg_y_ff || (ya > yb);

   ugsb_store #(
      .CELLS  (CELLS),
      .ENTRIES(ENTRIES),
      .CELL_W (CELL_W),
      .ENT_W  (ENT_W),
      .FILL_W (FILL_W)
   ) u_store (
      .clock       (clock),
      .ctl         (mem_ctl),
      .fill_rd_addr(fill_rd_addr),
      .fill_wr_addr(fill_wr_addr),
      .fill_wr_data(fill_wr_data),
      .fill_rd_data(fill_rd_data),
      .ent_rd_addr (ent_rd_addr),
      .ent_wr_addr (ent_wr_addr),
      .ent_wr_data (ent_wr_data),
      .ent_rd_data (ent_rd_data)
   );

   assign ent_new = !seen_ff[ent_rd_data];
   assign ent_hold = ent_new && pend_valid_ff && !out_free;
   assign idx_nxt = idx_ff + FILL_W'(1);
   assign ent_last = (idx_nxt == fill_cnt_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_SWEEP: begin
            if (sweep_ff == CELL_LAST) begin
               state_in = report_ff ? S_FINISH : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_CLEAR) begin
                  state_in = S_SWEEP;
               end else if (walk_start) begin
                  state_in = S_RANGE;
               end
            end
         end
         S_RANGE: begin
            if (div_done) begin
               state_in = (x_empty || y_empty) ? S_FINISH : S_SETUP;
            end
         end
         S_SETUP: state_in = S_CELL;
         S_CELL: state_in = S_FILL;
         S_FILL: begin
            if (mode_ff == MODE_QUERY && fill_rd_data != '0) begin
               state_in = S_ENT_RD;
            end else begin
               state_in = S_ADVANCE;
            end
         end
         S_ENT_RD: state_in = S_ENT_CHK;
         S_ENT_CHK: begin
            if (!ent_hold) begin
               state_in = ent_last ? S_ADVANCE : S_ENT_RD;
            end
         end
         S_ADVANCE: begin
            if (x_ff == x1_ff && y_ff == y1_ff) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_CELL;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      mem_ctl = '0;
      fill_rd_addr = cell_ff;
      fill_wr_addr = cell_ff;
      fill_wr_data = fill_rd_data + FILL_W'(1);
      ent_rd_addr = ent_base_ff + ENT_W'(idx_ff);
      ent_wr_addr = ent_base_ff + ENT_W'(fill_rd_data);
      ent_wr_data = id_ff;
      out_load = 1'b0;
      rsp_id_in = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in = rsp_last_ff;
      mode_in = mode_ff;
      id_in = id_ff;
      report_in = report_ff;
      lo_neg_x_in = lo_neg_x_ff;
      hi_neg_x_in = hi_neg_x_ff;
      lo_neg_y_in = lo_neg_y_ff;
      hi_neg_y_in = hi_neg_y_ff;
      sweep_in = sweep_ff;
      x0_in = x0_ff;
      x1_in = x1_ff;
      y0_in = y0_ff;
      y1_in = y1_ff;
      x_in = x_ff;
      y_in = y_ff;
      row_in = row_ff;
      cell_in = cell_ff;
      ent_base_in = ent_base_ff;
      fill_cnt_in = fill_cnt_ff;
      idx_in = idx_ff;
      seen_in = seen_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in = pend_id_ff;
      dropped_in = dropped_ff;
      case (state_ff)
         S_SWEEP: begin
            mem_ctl.fill_wr = 1'b1;
            fill_wr_addr = sweep_ff;
            fill_wr_data = '0;
            sweep_in = sweep_ff + CELL_W'(1);
         end
         S_IDLE: begin
            if (accept) begin
               mode_in = req_mode;
               id_in = req_sprite_id;
               report_in = (req_mode == MODE_CLEAR);
               lo_neg_x_in = ex_lo[EDGE_W-1];
               hi_neg_x_in = ex_hi[EDGE_W-1];
               lo_neg_y_in = ey_lo[EDGE_W-1];
               hi_neg_y_in = ey_hi[EDGE_W-1];
               sweep_in = '0;
               seen_in = '0;
               pend_valid_in = 1'b0;
               dropped_in = 1'b0;
            end
         end
         S_RANGE: begin
            x0_in = X_W'(xa);
            x1_in = X_W'(xb);
            y0_in = Y_W'(ya);
            y1_in = Y_W'(yb);
         end
         S_SETUP: begin
            row_in = CELL_W'(y0_ff * CELLS_PER_ROW);
            cell_in = CELL_W'(y0_ff * CELLS_PER_ROW + x0_ff);
            x_in = x0_ff;
            y_in = y0_ff;
         end
         S_CELL: begin
            mem_ctl.fill_rd = 1'b1;
            ent_base_in = ENT_W'(cell_ff * CELL_CAPACITY);
         end
         S_FILL: begin
            if (mode_ff == MODE_INSERT) begin
               if (fill_rd_data < CAP_F) begin
                  mem_ctl.ent_wr = 1'b1;
                  mem_ctl.fill_wr = 1'b1;
               end else begin
                  dropped_in = 1'b1;
               end
            end else begin
               fill_cnt_in = fill_rd_data;
               idx_in = '0;
            end
         end
         S_ENT_RD: begin
            mem_ctl.ent_rd = 1'b1;
         end
         S_ENT_CHK: begin
            if (!ent_hold) begin
               idx_in = idx_nxt;
               if (ent_new) begin
                  seen_in[ent_rd_data] = 1'b1;
                  pend_valid_in = 1'b1;
                  pend_id_in = ent_rd_data;
                  if (pend_valid_ff) begin
                     out_load = 1'b1;
                     rsp_id_in = pend_id_ff;
                     rsp_status_in = STATUS_FOUND;
                     rsp_last_in = 1'b0;
                  end
               end
            end
         end
         S_ADVANCE: begin
            if (x_ff == x1_ff) begin
               if (y_ff != y1_ff) begin
                  x_in = x0_ff;
                  y_in = y_ff + Y_W'(1);
                  row_in = CELL_W'(row_ff + CELLS_PER_ROW);
                  cell_in = CELL_W'(row_ff + CELLS_PER_ROW + x0_ff);
               end
            end else begin
               x_in = x_ff + X_W'(1);
               cell_in = cell_ff + CELL_W'(1);
            end
         end
         S_FINISH: begin
            if (out_free) begin
               out_load = 1'b1;
               rsp_last_in = 1'b1;
               case (mode_ff)
                  MODE_CLEAR: begin
                     rsp_id_in = '0;
                     rsp_status_in = STATUS_CLEARED;
                  end
                  MODE_INSERT: begin
                     rsp_id_in = id_ff;
                     rsp_status_in = dropped_ff ? STATUS_DROPPED : STATUS_INSERTED;
                  end
                  default: begin
                     rsp_id_in = pend_valid_ff ? pend_id_ff : '0;
                     rsp_status_in = pend_valid_ff ? STATUS_FOUND : STATUS_EMPTY;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         sweep_ff <= '0;
         report_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         seen_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         report_ff <= report_in;
         pend_valid_ff <= pend_valid_in;
         seen_ff <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      id_ff <= id_in;
      lo_neg_x_ff <= lo_neg_x_in;
      hi_neg_x_ff <= hi_neg_x_in;
      lo_neg_y_ff <= lo_neg_y_in;
      hi_neg_y_ff <= hi_neg_y_in;
      x0_ff <= x0_in;
      x1_ff <= x1_in;
      y0_ff <= y0_in;
      y1_ff <= y1_in;
      x_ff <= x_in;
      y_ff <= y_in;
      row_ff <= row_in;
      cell_ff <= cell_in;
      ent_base_ff <= ent_base_in;
      fill_cnt_ff <= fill_cnt_in;
      idx_ff <= idx_in;
      pend_id_ff <= pend_id_in;
      dropped_ff <= dropped_in;
      rsp_id_ff <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found_id = rsp_id_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last = rsp_last_ff;

   `UGSB_ASSERT_IMP(a_walk_in_range, clock, reset, state_ff == S_CELL, (x_ff <= x1_ff) && (y_ff <= y1_ff))
   `UGSB_ASSERT_IMP(a_pend_seen, clock, reset, pend_valid_ff, seen_ff[pend_id_ff])
   `UGSB_ASSERT_IMP(a_idle_div_quiet, clock, reset, state_ff == S_IDLE, !div_busy)
endmodule

### test/uniform_grid_sprite_broadphase_core_tb.sv
// Self-checking testbench for the uniform grid sprite broadphase core.
module uniform_grid_sprite_broadphase_core_tb;
   import ugsb_pkg::*;

   localparam int CW = 32;
   localparam int CH = 32;
   localparam int ROW_CELLS = 16;
   localparam int COL_CELLS = 8;
   localparam int CAPACITY = 16;
   localparam int GRID = ROW_CELLS * COL_CELLS;
   localparam int CYCLE_LIMIT = 20000000;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0] found_id;
      logic [STATUS_W-1:0] status;
      logic last;
   } result_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [MODE_W-1:0] req_mode = MODE_CLEAR;
   logic signed [COORD_W-1:0] req_center_x = '0;
   logic signed [COORD_W-1:0] req_center_y = '0;
   logic [SIZE_W-1:0] req_box_width = '0;
   logic [SIZE_W-1:0] req_box_height = '0;
   logic [ID_W-1:0] req_sprite_id = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ID_W-1:0] rsp_found_id;
   logic [STATUS_W-1:0] rsp_status;
   logic rsp_last;

   int fill_count[GRID];
   logic [ID_W-1:0] cell_ids[GRID][CAPACITY];
   result_beat_type pending_results[$];
   int error_count = 0;
   int cycle_count = 0;
   int hold_cycles = 0;
   bit stall_random = 1'b1;

   uniform_grid_sprite_broadphase_core dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("uniform_grid_sprite_broadphase_core_tb: done, errors");
         $finish;
      end
   end

   function automatic int short_or_long_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Result side: compare each beat against the oldest prediction and drive rsp_stall.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("unexpected beat id=%0d status=%0d", rsp_found_id, rsp_status);
               error_count++;
            end else begin
               result_beat_type want;
               want = pending_results.pop_front();
               if (rsp_found_id !== want.found_id) begin
                  $error("found_id expected %0d actual %0d", want.found_id, rsp_found_id);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last expected %0d actual %0d", want.last, rsp_last);
                  error_count++;
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_stall <= 1'b1;
         end else if (stall_random) begin
            rsp_stall <= ($urandom_range(0, 99) < 25);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic bit cell_span(int center, int size, int cell_size, int cells,
                                    output int first, output int final_cell);
      int lo;
      int hi;
      lo = 2 * center - size;
      hi = 2 * center + size;
      first = 0;
      final_cell = -1;
      if (hi < 0) return 1'b0;
      first = (lo < 0) ? 0 : lo / (2 * cell_size);
      final_cell = hi / (2 * cell_size);
      if (final_cell > cells - 1) final_cell = cells - 1;
      return first <= final_cell;
   endfunction

   task automatic predict_grid_op(logic [MODE_W-1:0] mode, int cx, int cy, int w, int h,
                                  logic [ID_W-1:0] id);
      int x0, x1, y0, y1, c, n;
      bit covered;
      bit dropped;
      logic [IDS-1:0] seen;
      result_beat_type beat;
      if (mode == MODE_CLEAR) begin
         foreach (fill_count[i]) fill_count[i] = 0;
         pending_results.push_back('{'0, STATUS_CLEARED, 1'b1});
         return;
      end
      if (mode != MODE_INSERT && mode != MODE_QUERY) return;
      covered = cell_span(cx, w, CW, ROW_CELLS, x0, x1);
      if (covered) covered = cell_span(cy, h, CH, COL_CELLS, y0, y1);
      if (mode == MODE_INSERT) begin
         dropped = 1'b0;
         if (covered)
            for (int y = y0; y <= y1; y++)
               for (int x = x0; x <= x1; x++) begin
                  c = y * ROW_CELLS + x;
                  if (fill_count[c] < CAPACITY) begin
                     cell_ids[c][fill_count[c]] = id;
                     fill_count[c]++;
                  end else dropped = 1'b1;
               end
         pending_results.push_back('{id, dropped ? STATUS_DROPPED : STATUS_INSERTED, 1'b1});
         return;
      end
      seen = '0;
      n = 0;
      if (covered)
         for (int y = y0; y <= y1; y++)
            for (int x = x0; x <= x1; x++) begin
               c = y * ROW_CELLS + x;
               for (int i = 0; i < fill_count[c]; i++)
                  if (!seen[cell_ids[c][i]]) begin
                     seen[cell_ids[c][i]] = 1'b1;
                     pending_results.push_back('{cell_ids[c][i], STATUS_FOUND, 1'b0});
                     n++;
                  end
            end
      if (n == 0) pending_results.push_back('{'0, STATUS_EMPTY, 1'b1});
      else begin
         beat = pending_results.pop_back();
         beat.last = 1'b1;
         pending_results.push_back(beat);
      end
   endtask

   task automatic send_beat(logic [MODE_W-1:0] mode, int cx, int cy, int w, int h,
                            int id, bit gaps = 1'b1);
      int gap;
      gap = gaps ? short_or_long_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_center_x <= COORD_W'(cx);
      req_center_y <= COORD_W'(cy);
      req_box_width <= SIZE_W'(w);
      req_box_height <= SIZE_W'(h);
      req_sprite_id <= ID_W'(id);
      predict_grid_op(mode, cx, cy, w, h, ID_W'(id));
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic test_directed();
      send_beat(MODE_QUERY, 100, 100, 2047, 2047, 0);
      send_beat(MODE_INSERT, 0, 0, 0, 0, 0);
      send_beat(MODE_INSERT, 2047, 2047, 2047, 2047, 63);
      send_beat(MODE_INSERT, -2048, -2048, 2047, 2047, 42);
      send_beat(MODE_INSERT, -1, 5, 1, 1, 7);
      send_beat(MODE_INSERT, 5, -1, 3, 3, 9);
      send_beat(MODE_INSERT, 600, 300, 10, 10, 21);
      send_beat(MODE_INSERT, 16, 16, 0, 2047, 5);
      send_beat(MODE_QUERY, 0, 0, 0, 0, 0);
      send_beat(MODE_QUERY, 2047, -2048, 2047, 2047, 0);
      send_beat(MODE_QUERY, -2048, -2048, 0, 0, 0);
      send_beat(MODE_UNUSED, 100, 100, 50, 50, 12);
      send_beat(MODE_QUERY, 255, 127, 2047, 2047, 0);
      for (int i = 0; i < 18; i++) send_beat(MODE_INSERT, 40, 40, 2, 2, i, 1'b0);
      send_beat(MODE_QUERY, 40, 40, 2, 2, 0);
      send_beat(MODE_CLEAR, -2048, 2047, 2047, 0, 63);
      send_beat(MODE_QUERY, 255, 127, 2047, 2047, 0);
      wait_drained();
   endtask

   task automatic send_random_op(int kind);
      int cx, cy, w, h;
      if ($urandom_range(0, 9) == 0) begin
         cx = $urandom_range(0, 4095) - 2048;
         cy = $urandom_range(0, 4095) - 2048;
         w = $urandom_range(0, 2047);
         h = $urandom_range(0, 2047);
      end else begin
         cx = $urandom_range(0, 560) - 20;
         cy = $urandom_range(0, 300) - 20;
         w = $urandom_range(0, 90);
         h = $urandom_range(0, 90);
      end
      send_beat(MODE_W'(kind), cx, cy, w, h, $urandom_range(0, 63));
   endtask

   task automatic test_random_traffic();
      int roll;
      for (int i = 0; i < 380; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 2) send_random_op(MODE_CLEAR);
         else if (roll < 4) send_random_op(MODE_UNUSED);
         else if (roll < 55) send_random_op(MODE_INSERT);
         else send_random_op(MODE_QUERY);
         if (i == 150) begin
            stall_random = 1'b0;
            wait_drained();
            stall_random = 1'b1;
         end
      end
      wait_drained();
   endtask

   task automatic test_long_backpressure();
      hold_cycles = 400;
      for (int i = 0; i < 6; i++) send_random_op(i[0] ? MODE_QUERY : MODE_INSERT);
      send_beat(MODE_QUERY, 255, 127, 2047, 2047, 0, 1'b0);
      wait_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic();
      test_long_backpressure();
      if (error_count == 0) $display("uniform_grid_sprite_broadphase_core_tb: done, clean");
      else $display("uniform_grid_sprite_broadphase_core_tb: done, errors");
      $finish;
   end
endmodule
